FILE: rtl/fawdu_pkg.sv
`default_nettype none

package fawdu_pkg;

    // fixed number formats
    localparam int VALUE_W   = 32;
    localparam int FRAC_BITS = 16;
    localparam int STEP_W    = 32;
    localparam int WGT_W     = 17;
    localparam int SUM_W     = 64;

    // node queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // configuration register indexes
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_USE_WEIGHT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE  = 1'b1;

    // weight of exactly one
    localparam logic [WGT_W-1:0] WGT_ONE = WGT_W'(1) << FRAC_BITS;

    typedef struct packed {
        logic signed [VALUE_W-1:0] x_in;
        logic signed [VALUE_W-1:0] r_in;
        logic signed [VALUE_W-1:0] u_in;
        logic signed [VALUE_W-1:0] w_in;
        logic signed [VALUE_W-1:0] p_in;
        logic signed [VALUE_W-1:0] s_in;
        logic signed [VALUE_W-1:0] q_in;
        logic signed [VALUE_W-1:0] z_in;
        logic        [WGT_W-1:0]   inv_degree;
        logic                      last;
    } in_word_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] x_out;
        logic signed [VALUE_W-1:0] r_out;
        logic signed [VALUE_W-1:0] u_out;
        logic signed [VALUE_W-1:0] w_out;
        logic signed [SUM_W-1:0]   sum_ur;
        logic signed [SUM_W-1:0]   sum_us;
        logic signed [SUM_W-1:0]   sum_uw;
        logic signed [SUM_W-1:0]   sum_rr;
        logic                      done_res;
    } out_word_t;

    // updated node as it waits for the dot-product stages
    typedef struct packed {
        logic signed [VALUE_W-1:0] x;
        logic signed [VALUE_W-1:0] r;
        logic signed [VALUE_W-1:0] u;
        logic signed [VALUE_W-1:0] w;
        logic signed [VALUE_W-1:0] s;
        logic        [WGT_W-1:0]   weight;
        logic                      last;
    } node_t;

    // queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

`default_nettype wire

FILE: rtl/fawdu_front.sv
`default_nettype none

module fawdu_front (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            node_valid,
    output logic                                 node_stall,
    input  wire fawdu_pkg::in_word_t             node_word,
    input  wire logic                            cfg_valid,
    input  wire logic [fawdu_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [fawdu_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire fawdu_pkg::q_status_t            q_status,
    output logic                                 push,
    output fawdu_pkg::node_t                     push_node
);

    localparam int V  = fawdu_pkg::VALUE_W;
    localparam int F  = fawdu_pkg::FRAC_BITS;
    localparam int PW = fawdu_pkg::STEP_W + V;

    // step product clamped to V+1 bits
    function automatic logic signed [V:0] sat_step(input logic signed [PW-1:0] a);
        logic signed [V:0] res;
        if (a[PW-1:V] == {(PW - V){a[V]}})
        begin
            res = a[V:0];
        end
        else
        begin
            res = {a[PW-1], {V{~a[PW-1]}}};
        end
        return res;
    endfunction

    // sum clamped to a value
    function automatic logic signed [V-1:0] sat_val(input logic signed [V+1:0] a);
        logic signed [V-1:0] res;
        if (a[V+1:V-1] == {3{a[V-1]}})
        begin
            res = a[V-1:0];
        end
        else
        begin
            res = {a[V+1], {(V - 1){~a[V+1]}}};
        end
        return res;
    endfunction

    logic                                 use_weight_reg;
    logic signed [fawdu_pkg::STEP_W-1:0]  step_size_reg;

    logic                                 f1_valid_reg;
    logic signed [PW-1:0]                 prod_p_reg, prod_s_reg, prod_q_reg, prod_z_reg;
    logic signed [V-1:0]                  x_reg, r_reg, u_reg, w_reg, s_reg;
    logic        [fawdu_pkg::WGT_W-1:0]   weight_reg;
    logic                                 last_reg;

    logic                                 advance;
    logic signed [PW-1:0]                 prod_p_next, prod_s_next, prod_q_next, prod_z_next;
    logic        [fawdu_pkg::WGT_W-1:0]   weight_next;
    logic signed [PW-1:0]                 sh_p, sh_s, sh_q, sh_z;
    logic signed [V+1:0]                  sum_x, sum_r, sum_u, sum_w;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            use_weight_reg <= 1'b0;
            step_size_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                fawdu_pkg::CFG_USE_WEIGHT: use_weight_reg <= cfg_data[0];
                fawdu_pkg::CFG_STEP_SIZE:  step_size_reg  <= $signed(cfg_data);
                default:                   use_weight_reg <= use_weight_reg;
            endcase
        end
    end

    // stage holds while its word cannot enter the queue
    assign node_stall = f1_valid_reg && q_status.full;
    assign advance    = !node_stall;
    assign push       = f1_valid_reg && !q_status.full;

    // step products and weight choice
    always_comb
    begin
        prod_p_next = PW'(step_size_reg) * PW'(node_word.p_in);
        prod_s_next = PW'(step_size_reg) * PW'(node_word.s_in);
        prod_q_next = PW'(step_size_reg) * PW'(node_word.q_in);
        prod_z_next = PW'(step_size_reg) * PW'(node_word.z_in);
        weight_next = use_weight_reg ? node_word.inv_degree : fawdu_pkg::WGT_ONE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            f1_valid_reg <= node_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && node_valid)
        begin
            prod_p_reg <= prod_p_next;
            prod_s_reg <= prod_s_next;
            prod_q_reg <= prod_q_next;
            prod_z_reg <= prod_z_next;
            x_reg      <= node_word.x_in;
            r_reg      <= node_word.r_in;
            u_reg      <= node_word.u_in;
            w_reg      <= node_word.w_in;
            s_reg      <= node_word.s_in;
            weight_reg <= weight_next;
            last_reg   <= node_word.last;
        end
    end

    // floor shift, clamp and update
    always_comb
    begin
        sh_p  = prod_p_reg >>> F;
        sh_s  = prod_s_reg >>> F;
        sh_q  = prod_q_reg >>> F;
        sh_z  = prod_z_reg >>> F;
        sum_x = (V + 2)'(x_reg) + (V + 2)'(sat_step(sh_p));
        sum_r = (V + 2)'(r_reg) - (V + 2)'(sat_step(sh_s));
        sum_u = (V + 2)'(u_reg) - (V + 2)'(sat_step(sh_q));
        sum_w = (V + 2)'(w_reg) - (V + 2)'(sat_step(sh_z));
        push_node.x      = sat_val(sum_x);
        push_node.r      = sat_val(sum_r);
        push_node.u      = sat_val(sum_u);
        push_node.w      = sat_val(sum_w);
        push_node.s      = s_reg;
        push_node.weight = weight_reg;
        push_node.last   = last_reg;
    end

endmodule

`default_nettype wire

FILE: rtl/fawdu_queue.sv
`default_nettype none

module fawdu_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire fawdu_pkg::node_t push_node,
    input  wire logic             pop,
    output fawdu_pkg::node_t      head_node,
    output fawdu_pkg::q_status_t  q_status
);

    localparam int DEPTH = fawdu_pkg::QUEUE_DEPTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    fawdu_pkg::node_t   entry_reg [DEPTH];
    logic [AW-1:0]      wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]      count_reg;

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_node;
        end
    end

    assign head_node      = entry_reg[rd_ptr_reg];
    assign q_status.full  = (count_reg == CW'(DEPTH));
    assign q_status.empty = (count_reg == '0);

endmodule

`default_nettype wire

FILE: rtl/fawdu_back.sv
`default_nettype none

module fawdu_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire fawdu_pkg::q_status_t q_status,
    input  wire fawdu_pkg::node_t     head_node,
    output logic                      pop,
    output logic                      res_valid,
    input  wire logic                 res_stall,
    output fawdu_pkg::out_word_t      res_word
);

    localparam int V   = fawdu_pkg::VALUE_W;
    localparam int F   = fawdu_pkg::FRAC_BITS;
    localparam int S   = fawdu_pkg::SUM_W;
    localparam int PV  = 2 * V;
    localparam int TW  = PV - F;
    localparam int WP  = TW + fawdu_pkg::WGT_W + 1;
    localparam int LANES = 4;

    // lane order: u*r, u*s, u*w, r*r
    localparam int L_UR = 0;
    localparam int L_US = 1;
    localparam int L_UW = 2;
    localparam int L_RR = 3;

    function automatic logic signed [S-1:0] add_sat(input logic signed [S-1:0] a,
                                                    input logic signed [S-1:0] b);
        logic signed [S-1:0] sum;
        logic signed [S-1:0] res;
        sum = a + b;
        if ((a[S-1] == b[S-1]) && (sum[S-1] != a[S-1]))
        begin
            res = {a[S-1], {(S - 1){~a[S-1]}}};
        end
        else
        begin
            res = sum;
        end
        return res;
    endfunction

    logic                                 advance;

    // stage 1: truncated pair products
    logic                                 b1_valid_reg;
    logic signed [TW-1:0]                 b1_t_reg [LANES];
    logic signed [V-1:0]                  b1_x_reg, b1_r_reg, b1_u_reg, b1_w_reg;
    logic        [fawdu_pkg::WGT_W-1:0]   b1_weight_reg;
    logic                                 b1_last_reg;

    // stage 2: weighted terms
    logic                                 b2_valid_reg;
    logic signed [S-1:0]                  b2_term_reg [LANES];
    logic signed [V-1:0]                  b2_x_reg, b2_r_reg, b2_u_reg, b2_w_reg;
    logic                                 b2_last_reg;

    // stage 3: accumulators and result register
    logic signed [S-1:0]                  acc_reg [LANES];
    logic                                 res_valid_reg;
    fawdu_pkg::out_word_t                 res_word_reg;

    logic signed [V-1:0]                  op_a [LANES];
    logic signed [V-1:0]                  op_b [LANES];
    logic signed [PV-1:0]                 pair_prod [LANES];
    logic signed [PV-1:0]                 pair_sh [LANES];
    logic signed [WP-1:0]                 wgt_prod [LANES];
    logic signed [WP-1:0]                 wgt_sh [LANES];
    logic signed [S-1:0]                  acc_next [LANES];

    assign advance   = !res_valid_reg || !res_stall;
    assign pop       = advance && !q_status.empty;
    assign res_valid = res_valid_reg;
    assign res_word  = res_word_reg;

    // operand routing and products per lane
    always_comb
    begin
        op_a[L_UR] = head_node.u;
        op_b[L_UR] = head_node.r;
        op_a[L_US] = head_node.u;
        op_b[L_US] = head_node.s;
        op_a[L_UW] = head_node.u;
        op_b[L_UW] = head_node.w;
        op_a[L_RR] = head_node.r;
        op_b[L_RR] = head_node.r;
        for (int i = 0; i < LANES; i++)
        begin
            pair_prod[i] = PV'(op_a[i]) * PV'(op_b[i]);
            pair_sh[i]   = pair_prod[i] >>> F;
            wgt_prod[i]  = WP'(b1_t_reg[i]) * WP'($signed({1'b0, b1_weight_reg}));
            wgt_sh[i]    = wgt_prod[i] >>> F;
            acc_next[i]  = add_sat(acc_reg[i], b2_term_reg[i]);
        end
    end

    // stage valids and accumulators
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg  <= 1'b0;
            b2_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            for (int i = 0; i < LANES; i++)
            begin
                acc_reg[i] <= '0;
            end
        end
        else if (advance)
        begin
            b1_valid_reg  <= !q_status.empty;
            b2_valid_reg  <= b1_valid_reg;
            res_valid_reg <= b2_valid_reg;
            if (b2_valid_reg)
            begin
                for (int i = 0; i < LANES; i++)
                begin
                    acc_reg[i] <= b2_last_reg ? '0 : acc_next[i];
                end
            end
        end
    end

    // stage payloads
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            if (!q_status.empty)
            begin
                for (int i = 0; i < LANES; i++)
                begin
                    b1_t_reg[i] <= pair_sh[i][TW-1:0];
                end
                b1_x_reg      <= head_node.x;
                b1_r_reg      <= head_node.r;
                b1_u_reg      <= head_node.u;
                b1_w_reg      <= head_node.w;
                b1_weight_reg <= head_node.weight;
                b1_last_reg   <= head_node.last;
            end
            if (b1_valid_reg)
            begin
                for (int i = 0; i < LANES; i++)
                begin
                    b2_term_reg[i] <= wgt_sh[i][S-1:0];
                end
                b2_x_reg    <= b1_x_reg;
                b2_r_reg    <= b1_r_reg;
                b2_u_reg    <= b1_u_reg;
                b2_w_reg    <= b1_w_reg;
                b2_last_reg <= b1_last_reg;
            end
            if (b2_valid_reg)
            begin
                res_word_reg.x_out    <= b2_x_reg;
                res_word_reg.r_out    <= b2_r_reg;
                res_word_reg.u_out    <= b2_u_reg;
                res_word_reg.w_out    <= b2_w_reg;
                res_word_reg.sum_ur   <= acc_next[L_UR];
                res_word_reg.sum_us   <= acc_next[L_US];
                res_word_reg.sum_uw   <= acc_next[L_UW];
                res_word_reg.sum_rr   <= acc_next[L_RR];
                res_word_reg.done_res <= b2_last_reg;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/fused_axpy_weighted_dot_update.sv
// Fused AXPY and weighted dot update for a pipelined CG solver node stream.
// node channel (node_valid/node_stall/node_word): one node word per accept,
//   entries x r u w p s q z, inverse degree weight and a last flag.
// res channel (res_valid/res_stall/res_word): one result word per node, the
//   updated x r u w and the four running sums including this node; done_res
//   follows last, and the sums restart from zero after that word.
// cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): use_weight at index 0,
//   step_size at index 1; cfg_ready is always high, write only while idle.
// Path: front register, queue, product and term registers, result register.
// Throughput: one node per cycle while res_stall is low; the accumulator
//   add-and-clamp loop in the back stages keeps up with this rate.
// Reset clears config, accumulators, pipeline valids and the node queue.
// When the receiver stalls, the back stages hold, the 4-entry queue takes up
//   to four more words from the front, then node_stall rises.
`default_nettype none

module fused_axpy_weighted_dot_update (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             node_valid,
    output logic                                  node_stall,
    input  wire fawdu_pkg::in_word_t              node_word,
    output logic                                  res_valid,
    input  wire logic                             res_stall,
    output fawdu_pkg::out_word_t                  res_word,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [fawdu_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [fawdu_pkg::CFG_DATA_W-1:0] cfg_data
);

    logic                 push;
    logic                 pop;
    fawdu_pkg::node_t     push_node;
    fawdu_pkg::node_t     head_node;
    fawdu_pkg::q_status_t q_status;

    assign cfg_ready = 1'b1;

    // axpy update and weight choice
    fawdu_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .node_valid (node_valid),
        .node_stall (node_stall),
        .node_word  (node_word),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .q_status   (q_status),
        .push       (push),
        .push_node  (push_node)
    );

    // node queue
    fawdu_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_node (push_node),
        .pop       (pop),
        .head_node (head_node),
        .q_status  (q_status)
    );

    // dot products and running sums
    fawdu_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_status  (q_status),
        .head_node (head_node),
        .pop       (pop),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_word  (res_word)
    );

endmodule

`default_nettype wire

FILE: rtl/fawdu_checker.sv
`default_nettype none

module fawdu_checker (
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 res_valid,
    input wire logic                 res_stall,
    input wire fawdu_pkg::out_word_t res_word,
    input wire logic                 cfg_ready
);

    // no result survives reset
    a_reset_clears: assert property (@(posedge clk) !rst_n |-> !res_valid)
        else $error("result valid during reset");

    // config port never back-pressures
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
        else $error("config port not ready");

    // stalled result stays offered
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid)
        else $error("result dropped while stalled");

    // stalled result word holds
    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> $stable(res_word))
        else $error("result word changed while stalled");

endmodule

bind fused_axpy_weighted_dot_update fawdu_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_word  (res_word),
    .cfg_ready (cfg_ready)
);

`default_nettype wire
